// ===== sv/tshr_pkg.sv =====
package tshr_pkg;

  // operation codes of an input transaction
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // interval register value after reset, in microseconds
  localparam logic [31:0] INTERVAL_RESET = 32'd60000000;

  // one input transaction as held in the input register
  typedef struct packed {
    logic               operation;
    logic [62:0]        now_us;
    logic [15:0]        co2_ppm;
    logic signed [15:0] temp_q8;
    logic [5:0]         read_index;
  } item_t;

  // q8.8 degrees to tenths of a degree, truncated toward zero
  function automatic logic [11:0] q8_to_tenths(input logic [15:0] raw);
    logic        neg;
    logic [16:0] mag;
    logic [20:0] prod;
    logic [12:0] t;
    logic [12:0] code;
    neg  = raw[15];
    mag  = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    // times ten as shift and add
    prod = {mag, 3'b000} + {2'b00, mag, 1'b0} + 21'd0;
    t    = prod[20:8];
    code = neg ? (13'd0 - t) : t;
    return code[11:0];
  endfunction

endpackage

// ===== sv/timed_sample_history_ring.sv =====
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_ready    | operation, now_us, co2_ppm, temp_q8, read_index
// out      | out_valid / out_ready  | valid_res, pushed, co2_out, temp_tenths,
//          |                        | stored_count, total_stored
// cfg      | cfg_valid / cfg_ready  | interval_us
//
// one transaction per cycle while the result register is not stalled; a result passes the
// input register, then state update and sample memory read into the result register
// synchronous active-low reset clears pointers, counts and timestamps and loads the
// interval register with its default; sample memory is not cleared, so ready is high
// right after reset
// a stalled result holds the result register and the input register, so at most
// two transactions are in flight; cfg_ready is always high
module timed_sample_history_ring #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [62:0]        in_now_us,
  input  logic [15:0]        in_co2_ppm,
  input  logic signed [15:0] in_temp_q8,
  input  logic [5:0]         in_read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic               out_pushed,
  output logic [15:0]        out_co2_out,
  output logic signed [11:0] out_temp_tenths,
  output logic [6:0]         out_stored_count,
  output logic [31:0]        out_total_stored,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_interval_us
);

  tshr_pkg::item_t in_item;
  tshr_pkg::item_t s1_item;
  logic            s1_valid;
  logic            advance;
  logic            cfg_we;

  // pack the input transaction
  assign in_item.operation  = in_operation;
  assign in_item.now_us     = in_now_us;
  assign in_item.co2_ppm    = in_co2_ppm;
  assign in_item.temp_q8    = in_temp_q8;
  assign in_item.read_index = in_read_index;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tshr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tshr_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_we),
    .cfg_interval_us  (cfg_interval_us),
    .s1_valid         (s1_valid),
    .s1_item          (s1_item),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_pushed       (out_pushed),
    .out_co2_out      (out_co2_out),
    .out_temp_tenths  (out_temp_tenths),
    .out_stored_count (out_stored_count),
    .out_total_stored (out_total_stored)
  );

endmodule

// ===== sv/tshr_in_reg.sv =====
module tshr_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tshr_pkg::item_t    in_item,
  input  logic               advance,
  output logic               s1_valid,
  output tshr_pkg::item_t    s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  tshr_pkg::item_t item_r;
  logic            take;

  // the stage takes a transaction when empty or when its content moves on
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    priority if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== sv/tshr_core.sv =====
module tshr_core #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_interval_us,
  input  logic               s1_valid,
  input  tshr_pkg::item_t    s1_item,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic               out_pushed,
  output logic [15:0]        out_co2_out,
  output logic signed [11:0] out_temp_tenths,
  output logic [6:0]         out_stored_count,
  output logic [31:0]        out_total_stored
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int CW = (FW > 6) ? FW : 6;
  localparam int XW = (FW > 7) ? FW : 7;

  // ring state
  logic [31:0]    interval_r;
  logic [AW-1:0]  wpos_r, wpos_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [31:0]    total_r, total_nxt;
  logic [62:0]    last_r, last_nxt;
  logic [63:0]    deadline_r, deadline_nxt;
  logic           seen_r, seen_nxt;

  // sample memories
  logic [15:0]    co2_mem  [DEPTH];
  logic [11:0]    temp_mem [DEPTH];
  logic [15:0]    co2_q_r;
  logic [11:0]    temp_q_r;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           valid_res_r;
  logic           pushed_r;
  logic [FW-1:0]  count_r;

  logic           fire;
  logic           is_push;
  logic           due;
  logic           store;
  logic           hit;
  logic           rd_en;
  logic [CW-1:0]  idx_ext;
  logic [CW-1:0]  fill_ext;
  logic [FW-1:0]  idx_f;
  logic [SW-1:0]  pos_sum;
  logic [SW-1:0]  pos_wrap;
  logic [AW-1:0]  rd_addr;
  logic [63:0]    now_ext;
  logic [XW-1:0]  count_ext;

  assign advance = !out_valid_r || out_ready;
  assign fire    = s1_valid && advance;
  assign is_push = (s1_item.operation == tshr_pkg::OP_PUSH);

  // rate limit: deadline holds last stored time plus interval
  assign now_ext = {1'b0, s1_item.now_us};
  assign due     = !seen_r ||
                   ((s1_item.now_us >= last_r) && (now_ext >= deadline_r));
  assign store   = fire && is_push && due;

  // read address counted from the oldest sample
  assign idx_ext  = CW'(s1_item.read_index);
  assign fill_ext = CW'(fill_r);
  assign hit      = (idx_ext < fill_ext);
  assign idx_f    = idx_ext[FW-1:0];
  assign pos_sum  = SW'(wpos_r) + SW'(DEPTH) - SW'(fill_r) + SW'(idx_f);
  assign pos_wrap = (pos_sum >= SW'(DEPTH)) ? (pos_sum - SW'(DEPTH)) : pos_sum;
  assign rd_addr  = pos_wrap[AW-1:0];
  assign rd_en    = fire && !is_push && hit;

  // next ring state
  always_comb begin
    wpos_nxt     = wpos_r;
    fill_nxt     = fill_r;
    total_nxt    = total_r;
    last_nxt     = last_r;
    deadline_nxt = deadline_r;
    seen_nxt     = seen_r;
    if (store) begin
      wpos_nxt     = (wpos_r == AW'(DEPTH - 1)) ? '0 : (wpos_r + 1'b1);
      fill_nxt     = (fill_r == FW'(DEPTH)) ? fill_r : (fill_r + 1'b1);
      total_nxt    = total_r + 32'd1;
      last_nxt     = s1_item.now_us;
      deadline_nxt = now_ext + {32'd0, interval_r};
      seen_nxt     = 1'b1;
    end else if (cfg_valid) begin
      deadline_nxt = {1'b0, last_r} + {32'd0, cfg_interval_us};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= tshr_pkg::INTERVAL_RESET;
      wpos_r     <= '0;
      fill_r     <= '0;
      total_r    <= '0;
      last_r     <= '0;
      deadline_r <= {32'd0, tshr_pkg::INTERVAL_RESET};
      seen_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        interval_r <= cfg_interval_us;
      end
      wpos_r     <= wpos_nxt;
      fill_r     <= fill_nxt;
      total_r    <= total_nxt;
      last_r     <= last_nxt;
      deadline_r <= deadline_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // sample memories, one write and one registered read
  always_ff @(posedge clk) begin
    if (store) begin
      co2_mem[wpos_r]  <= s1_item.co2_ppm;
      temp_mem[wpos_r] <= tshr_pkg::q8_to_tenths(s1_item.temp_q8);
    end
    if (rd_en) begin
      co2_q_r  <= co2_mem[rd_addr];
      temp_q_r <= temp_mem[rd_addr];
    end
  end

  // result register control
  always_comb begin
    priority if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      valid_res_r <= !is_push && hit;
      pushed_r    <= store;
      count_r     <= fill_nxt;
    end
  end

  assign count_ext        = XW'(count_r);
  assign out_valid        = out_valid_r;
  assign out_valid_res    = valid_res_r;
  assign out_pushed       = pushed_r;
  assign out_co2_out      = valid_res_r ? co2_q_r : 16'd0;
  assign out_temp_tenths  = valid_res_r ? signed'(temp_q_r) : 12'sd0;
  assign out_stored_count = count_ext[6:0];
  assign out_total_stored = total_r;

  // fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count above depth");

  // until the ring is full the write position equals the fill count
  a_wpos_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FW'(DEPTH)) |-> (wpos_r == fill_r[AW-1:0]))
    else $error("write position out of step with fill count");

  // a stored sample bumps the running total by one
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> (total_r == $past(total_r) + 32'd1))
    else $error("total not advanced on store");

  // a result is never both a stored push and a hit read
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(valid_res_r && pushed_r))
    else $error("push and read flags both set");

  // nothing stored without a push transaction moving on
  a_store_src: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> $past(store))
    else $error("fill count changed without a store");

endmodule
